// ===== rtl/sg3_pkg.sv =====
// Shared constants, command/status structs and weight function for the
// 3x3x3 Sobel gradient block. No dependencies.
`default_nettype none
package sg3_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int MAX_DEPTH     = 1024;
   localparam int FRACTION_BITS = 15;

   localparam int DIM_W    = 9;
   localparam int DEPTH_W  = 11;
   localparam int COL_W    = 8;
   localparam int ROW_W    = 8;
   localparam int PLANE_W  = 10;
   localparam int VOXEL_W  = 16;
   localparam int UNIT_W   = 16;
   localparam int IDX_W    = 2;

   localparam int HIST_LEN = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
   localparam int HIST_AW  = $clog2(HIST_LEN);
   localparam int WH_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int ROFF_W   = $clog2(2 * MAX_WIDTH + 1);

   localparam int SUM_W    = 21;
   localparam int MAG_W    = SUM_W - 1;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int TOT_W    = SQ_W + 2;
   localparam int QUOT_W   = 2 * FRACTION_BITS + 3;
   localparam int ROOT_W   = FRACTION_BITS + 2;
   localparam int CNT_W    = 5;

   typedef enum logic [IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_DEPTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic take;
      logic issue;
      logic square;
      logic total;
      logic div_init;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic unit_store;
      logic out_load;
   } sg3_cmd_type;

   typedef struct packed {
      logic interior;
      logic issue_last;
      logic grad_zero;
      logic div_done;
      logic sqrt_done;
      logic comp_last;
      logic out_free;
   } sg3_stat_type;

   // weight of a tap: difference on the first axis, 1-2-1 on the other two
   function automatic logic signed [3:0] axis_weight(input logic [1:0] d_diff,
                                                     input logic [1:0] d_a,
                                                     input logic [1:0] d_b);
      logic signed [3:0] wd;
      logic signed [3:0] wa;
      logic signed [3:0] wb;
      case (d_diff)
         2'd0:    wd = -4'sd1;
         2'd2:    wd = 4'sd1;
         default: wd = 4'sd0;
      endcase
      wa = (d_a == 2'd1) ? 4'sd2 : 4'sd1;
      wb = (d_b == 2'd1) ? 4'sd2 : 4'sd1;
      return 4'(wd * wa * wb);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sg3_ctrl.sv =====
// Sequencer for the gradient block: read window, square, divide, root.
// Depends on sg3_pkg.
`default_nettype none
module sg3_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sg3_pkg::sg3_stat_type stat,
   output sg3_pkg::sg3_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_TAIL, S_SQUARE, S_TOTAL, S_CHECK, S_DIV_INIT,
      S_DIV, S_SQRT_INIT, S_SQRT, S_STORE, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && stat.interior) state_in = S_READ;
         end
         S_READ: begin
            cmd.issue = 1'b1;
            if (stat.issue_last) state_in = S_TAIL;
         end
         S_TAIL:   state_in = S_SQUARE;
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_TOTAL;
         end
         S_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK:  state_in = stat.grad_zero ? S_RESULT : S_DIV_INIT;
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_done) state_in = S_STORE;
         end
         S_STORE: begin
            cmd.unit_store = 1'b1;
            state_in       = stat.comp_last ? S_RESULT : S_DIV_INIT;
         end
         S_RESULT: begin
            cmd.out_load = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded while output busy");

   a_zero_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && stat.grad_zero) |=> state_ff == S_RESULT)
      else $error("zero gradient went through normalization");

   a_interior_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cmd.take && stat.interior) |=> state_ff == S_READ)
      else $error("interior voxel did not start window read");

   a_stall_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input open while busy");

endmodule
`default_nettype wire

// ===== rtl/sg3_dp.sv =====
// Datapath: history memory, position counters, window sums, shared
// divider and square-root unit, output register. Depends on sg3_pkg.
`default_nettype none
module sg3_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [sg3_pkg::IDX_W-1:0]             csr_index,
   input  wire logic [sg3_pkg::DEPTH_W-1:0]           csr_data,
   input  wire logic [sg3_pkg::VOXEL_W-1:0]           req_voxel_value,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output logic [sg3_pkg::COL_W-1:0]                  rsp_center_x,
   output logic [sg3_pkg::ROW_W-1:0]                  rsp_center_y,
   output logic [sg3_pkg::PLANE_W-1:0]                rsp_center_z,
   output logic signed [sg3_pkg::UNIT_W-1:0]          rsp_unit_x,
   output logic signed [sg3_pkg::UNIT_W-1:0]          rsp_unit_y,
   output logic signed [sg3_pkg::UNIT_W-1:0]          rsp_unit_z,
   output logic                                       rsp_zero_gradient,
   output logic                                       rsp_volume_end,
   input  wire sg3_pkg::sg3_cmd_type                  cmd,
   output sg3_pkg::sg3_stat_type                      stat
);

   localparam int DIM_W   = sg3_pkg::DIM_W;
   localparam int DEPTH_W = sg3_pkg::DEPTH_W;
   localparam int AW      = sg3_pkg::HIST_AW;
   localparam int SUM_W   = sg3_pkg::SUM_W;
   localparam int MAG_W   = sg3_pkg::MAG_W;
   localparam int SQ_W    = sg3_pkg::SQ_W;
   localparam int TOT_W   = sg3_pkg::TOT_W;
   localparam int QUOT_W  = sg3_pkg::QUOT_W;
   localparam int ROOT_W  = sg3_pkg::ROOT_W;
   localparam int UNIT_W  = sg3_pkg::UNIT_W;
   localparam int CNT_W   = sg3_pkg::CNT_W;
   localparam int WH_W    = sg3_pkg::WH_W;
   localparam int ROFF_W  = sg3_pkg::ROFF_W;
   localparam int DIV_STEPS  = QUOT_W - 1;
   localparam int SQRT_STEPS = ROOT_W - 1;
   localparam logic [UNIT_W-1:0] UNIT_POS_MAX = {1'b0, {(UNIT_W-1){1'b1}}};

   logic [15:0] hist_mem [sg3_pkg::HIST_LEN];

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [DEPTH_W-1:0] d_eff;
   logic [WH_W-1:0]    wh_ff;

   logic [sg3_pkg::COL_W-1:0]   col_ff;
   logic [sg3_pkg::ROW_W-1:0]   row_ff;
   logic [sg3_pkg::PLANE_W-1:0] plane_ff;
   logic [AW-1:0]               wp_ff, base_ff;
   logic                        row_end, plane_end, vol_end;

   logic [sg3_pkg::COL_W-1:0]   cx_ff;
   logic [sg3_pkg::ROW_W-1:0]   cy_ff;
   logic [sg3_pkg::PLANE_W-1:0] cz_ff;
   logic                        vend_ff;

   logic [1:0]        dx_ff, dy_ff, dz_ff, rdx_ff, rdy_ff, rdz_ff;
   logic [ROFF_W-1:0] row_off_ff;
   logic [AW-1:0]     plane_off_ff, back;
   logic [AW:0]       diff;
   logic [AW-1:0]     rd_addr;
   logic [15:0]       rd_data_ff;
   logic              rd_valid_ff;

   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] tap [3];
   logic signed [3:0]       wgt [3];
   logic [MAG_W-1:0]        mag [3];
   logic [SQ_W-1:0]         sq_ff [3];
   logic                    neg_ff [3];
   logic [TOT_W-1:0]        tot_ff;

   logic [1:0]        comp_ff;
   logic [TOT_W-1:0]  rem_ff;
   logic [TOT_W:0]    rem_sh;
   logic [TOT_W-1:0]  g2;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ROOT_W-1:0] root_ff, root_try;
   logic [2*ROOT_W-1:0] root_sq;
   logic [ROOT_W-1:0] mid;
   logic [UNIT_W-1:0] unit_val;
   logic [UNIT_W-1:0] unit_ff [3];

   logic rsp_valid_ff;

   always_comb begin
      w_eff = (width_ff < DIM_W'(3)) ? DIM_W'(3) :
              (width_ff > DIM_W'(sg3_pkg::MAX_WIDTH)) ? DIM_W'(sg3_pkg::MAX_WIDTH) : width_ff;
      h_eff = (height_ff < DIM_W'(3)) ? DIM_W'(3) :
              (height_ff > DIM_W'(sg3_pkg::MAX_HEIGHT)) ? DIM_W'(sg3_pkg::MAX_HEIGHT) :
              height_ff;
      d_eff = (depth_ff < DEPTH_W'(3)) ? DEPTH_W'(3) :
              (depth_ff > DEPTH_W'(sg3_pkg::MAX_DEPTH)) ? DEPTH_W'(sg3_pkg::MAX_DEPTH) :
              depth_ff;
      row_end   = {1'b0, col_ff} >= w_eff - DIM_W'(1);
      plane_end = {1'b0, row_ff} >= h_eff - DIM_W'(1);
      vol_end   = {1'b0, plane_ff} >= d_eff - DEPTH_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         depth_ff  <= DEPTH_W'(256);
      end else if (csr_write_enable) begin
         case (csr_index)
            sg3_pkg::CSR_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            sg3_pkg::CSR_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            sg3_pkg::CSR_DEPTH:  depth_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      wh_ff <= WH_W'(w_eff * h_eff);
   end

   // position counters and write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
         wp_ff    <= '0;
      end else if (cmd.take) begin
         wp_ff <= (wp_ff == AW'(sg3_pkg::HIST_LEN - 1)) ? '0 : wp_ff + AW'(1);
         if (!row_end) begin
            col_ff <= col_ff + 1'b1;
         end else begin
            col_ff <= '0;
            if (!plane_end) begin
               row_ff <= row_ff + 1'b1;
            end else begin
               row_ff   <= '0;
               plane_ff <= vol_end ? '0 : plane_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         base_ff <= wp_ff;
         cx_ff   <= col_ff - 1'b1;
         cy_ff   <= row_ff - 1'b1;
         cz_ff   <= plane_ff - 1'b1;
         vend_ff <= row_end && plane_end && vol_end;
      end
   end

   // window address walk
   always_comb begin
      back    = plane_off_ff + AW'(row_off_ff) + AW'(dx_ff);
      diff    = {1'b0, base_ff} - {1'b0, back};
      rd_addr = diff[AW] ? AW'(diff + (AW+1)'(sg3_pkg::HIST_LEN)) : diff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         dx_ff        <= '0;
         dy_ff        <= '0;
         dz_ff        <= '0;
         row_off_ff   <= '0;
         plane_off_ff <= '0;
      end else if (cmd.issue) begin
         if (dx_ff == 2'd2) begin
            dx_ff <= '0;
            if (dy_ff == 2'd2) begin
               dy_ff        <= '0;
               row_off_ff   <= '0;
               dz_ff        <= dz_ff + 2'd1;
               plane_off_ff <= plane_off_ff + AW'(wh_ff);
            end else begin
               dy_ff      <= dy_ff + 2'd1;
               row_off_ff <= row_off_ff + ROFF_W'(w_eff);
            end
         end else begin
            dx_ff <= dx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) hist_mem[wp_ff] <= req_voxel_value;
      if (cmd.issue) rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= cmd.issue;
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rdx_ff <= dx_ff;
         rdy_ff <= dy_ff;
         rdz_ff <= dz_ff;
      end
   end

   // weighted accumulation
   always_comb begin
      wgt[0] = sg3_pkg::axis_weight(rdx_ff, rdy_ff, rdz_ff);
      wgt[1] = sg3_pkg::axis_weight(rdy_ff, rdx_ff, rdz_ff);
      wgt[2] = sg3_pkg::axis_weight(rdz_ff, rdx_ff, rdy_ff);
      for (int i = 0; i < 3; i++) begin
         tap[i] = SUM_W'($signed({1'b0, rd_data_ff})) * SUM_W'(wgt[i]);
         mag[i] = sum_ff[i][SUM_W-1] ? MAG_W'(-sum_ff[i]) : MAG_W'(sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.take)             sum_ff[i] <= '0;
         else if (rd_valid_ff)     sum_ff[i] <= sum_ff[i] + tap[i];
         if (cmd.square) begin
            sq_ff[i]  <= mag[i] * mag[i];
            neg_ff[i] <= sum_ff[i][SUM_W-1];
         end
      end
      if (cmd.total) tot_ff <= TOT_W'(sq_ff[0]) + TOT_W'(sq_ff[1]) + TOT_W'(sq_ff[2]);
   end

   // shared restoring divider and square root
   always_comb begin
      case (comp_ff)
         2'd0:    g2 = TOT_W'(sq_ff[0]);
         2'd1:    g2 = TOT_W'(sq_ff[1]);
         default: g2 = TOT_W'(sq_ff[2]);
      endcase
      rem_sh   = {rem_ff, 1'b0};
      root_try = root_ff | (ROOT_W'(1) << cnt_ff);
      root_sq  = root_try * root_try;
      mid      = ROOT_W'(({1'b0, root_ff} + (ROOT_W+1)'(1)) >> 1);
      if (neg_ff[comp_ff]) begin
         unit_val = UNIT_W'((ROOT_W+1)'(1 << UNIT_W) - (ROOT_W+1)'(mid));
      end else begin
         unit_val = (mid > ROOT_W'(UNIT_POS_MAX)) ? UNIT_POS_MAX : UNIT_W'(mid);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         cnt_ff <= CNT_W'(DIV_STEPS - 1);
         if (g2 >= tot_ff) begin
            rem_ff  <= g2 - tot_ff;
            quot_ff <= QUOT_W'(1);
         end else begin
            rem_ff  <= g2;
            quot_ff <= '0;
         end
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, tot_ff}) begin
            rem_ff  <= TOT_W'(rem_sh - {1'b0, tot_ff});
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= TOT_W'(rem_sh);
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end else if (cmd.sqrt_init) begin
         cnt_ff  <= CNT_W'(SQRT_STEPS);
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (root_sq <= (2*ROOT_W)'(quot_ff)) root_ff <= root_try;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.total) begin
         comp_ff <= '0;
         for (int i = 0; i < 3; i++) unit_ff[i] <= '0;
      end else if (cmd.unit_store) begin
         comp_ff          <= comp_ff + 2'd1;
         unit_ff[comp_ff] <= unit_val;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_center_x      <= cx_ff;
         rsp_center_y      <= cy_ff;
         rsp_center_z      <= cz_ff;
         rsp_unit_x        <= unit_ff[0];
         rsp_unit_y        <= unit_ff[1];
         rsp_unit_z        <= unit_ff[2];
         rsp_zero_gradient <= (tot_ff == '0);
         rsp_volume_end    <= vend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.interior   = (col_ff >= 2) && (row_ff >= 2) && (plane_ff >= 2);
      stat.issue_last = (dx_ff == 2'd2) && (dy_ff == 2'd2) && (dz_ff == 2'd2);
      stat.grad_zero  = (tot_ff == '0);
      stat.div_done   = (cnt_ff == '0);
      stat.sqrt_done  = (cnt_ff == '0);
      stat.comp_last  = (comp_ff == 2'd2);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

// ===== rtl/sobel_gradient_3d.sv =====
// Border voxels are taken one per cycle while idle, with no result. An
// interior voxel goes through 27 history memory reads, then per axis a
// 32-step divide and a 17-step square root on one shared unit; both are
// skipped when the gradient is zero. One item is in work at a time.
// Reset (synchronous) clears counters and control; sizes return to 256.
// Top level of the 3x3x3 Sobel gradient; depends on sg3_pkg, sg3_ctrl, sg3_dp.
`default_nettype none
module sobel_gradient_3d (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [sg3_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [sg3_pkg::DEPTH_W-1:0]   csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sg3_pkg::VOXEL_W-1:0]   req_voxel_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sg3_pkg::COL_W-1:0]          rsp_center_x,
   output logic [sg3_pkg::ROW_W-1:0]          rsp_center_y,
   output logic [sg3_pkg::PLANE_W-1:0]        rsp_center_z,
   output logic signed [sg3_pkg::UNIT_W-1:0]  rsp_unit_x,
   output logic signed [sg3_pkg::UNIT_W-1:0]  rsp_unit_y,
   output logic signed [sg3_pkg::UNIT_W-1:0]  rsp_unit_z,
   output logic                               rsp_zero_gradient,
   output logic                               rsp_volume_end
);

   sg3_pkg::sg3_cmd_type  cmd;
   sg3_pkg::sg3_stat_type stat;

   sg3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sg3_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_voxel_value   (req_voxel_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_center_x      (rsp_center_x),
      .rsp_center_y      (rsp_center_y),
      .rsp_center_z      (rsp_center_z),
      .rsp_unit_x        (rsp_unit_x),
      .rsp_unit_y        (rsp_unit_y),
      .rsp_unit_z        (rsp_unit_z),
      .rsp_zero_gradient (rsp_zero_gradient),
      .rsp_volume_end    (rsp_volume_end),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
`default_nettype wire
